>>> rtl/core/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the dirty range tracker: the queued range
// word, the result word and the back end sequencer states.
// ----------------------------------------------------------------------------
package drt_pkg;

   // default table depth and depth of both word queues
   localparam int DRT_MAX_BLOCKS  = 16;
   localparam int DRT_QUEUE_DEPTH = 2;

   // field widths
   localparam int DRT_START_W  = 31;
   localparam int DRT_REQLEN_W = 31;
   localparam int DRT_LEN_W    = 32;
   localparam int DRT_END_W    = 33;

   // range word as it travels from the front end to the table
   typedef struct packed {
      logic [DRT_START_W-1:0]  range_start;
      logic [DRT_REQLEN_W-1:0] range_length;
      logic [DRT_END_W-1:0]    range_end;
   } drt_item_type;

   // result word
   typedef struct packed {
      logic overlap_found;
      logic table_overflow;
   } drt_rsp_type;

   localparam int DRT_ITEM_W = $bits(drt_item_type);
   localparam int DRT_RSP_W  = $bits(drt_rsp_type);

   // back end sequencer
   typedef enum logic {
      BK_COMPARE,
      BK_UPDATE
   } drt_back_state_type;

endpackage

>>> rtl/core/drt_queue.sv
// ----------------------------------------------------------------------------
// drt_queue
// Small first-in first-out word queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module drt_queue
   import drt_pkg::*;
#(
   parameter int WIDTH = DRT_ITEM_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic [WIDTH-1:0] wdata,
   output logic             empty,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata
);

   localparam int PtrW = (DRT_QUEUE_DEPTH > 1) ? $clog2(DRT_QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(DRT_QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DRT_QUEUE_DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_wr, do_rd;

   // handshake qualification
   assign full  = (count_ff == CntW'(DRT_QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = push && !full;
   assign do_rd = pop && !empty;
   assign rdata = slot_ff[rd_ptr_ff];

   // pointer and fill level update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DRT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DRT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

>>> rtl/core/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front
// Accepts write ranges, works out the exclusive end of each range and
// queues the word for the table logic.
// ----------------------------------------------------------------------------
module drt_front
   import drt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [DRT_START_W-1:0]  req_range_start,
   input  logic [DRT_REQLEN_W-1:0] req_range_length,
   output drt_item_type            head,
   output logic                    head_empty,
   input  logic                    head_pop
);

   drt_item_type          item;
   logic [DRT_ITEM_W-1:0] head_bits;

   // range end, exact in 33 bits
   always_comb begin
      item.range_start  = req_range_start;
      item.range_length = req_range_length;
      item.range_end    = DRT_END_W'(req_range_start) + DRT_END_W'(req_range_length);
   end

   // hand-off queue to the table logic
   drt_queue #(
      .WIDTH (DRT_ITEM_W)
   ) u_req_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .full  (req_full),
      .wdata (item),
      .empty (head_empty),
      .pop   (head_pop),
      .rdata (head_bits)
   );

   assign head = drt_item_type'(head_bits);

endmodule

>>> rtl/core/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back
// Block table: compares a queued range with all stored blocks at once, then
// resets, grows or appends in the update state and emits the result word.
// ----------------------------------------------------------------------------
module drt_back
   import drt_pkg::*;
#(
   parameter int MAX_BLOCKS = DRT_MAX_BLOCKS
) (
   input  logic         clock,
   input  logic         reset,
   input  drt_item_type head,
   input  logic         head_empty,
   output logic         head_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output drt_rsp_type  rsp_word
);

   localparam int IdxW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CntW = $clog2(MAX_BLOCKS + 1);

   // block table, one lane per entry
   logic [DRT_START_W-1:0] entry_start_ff  [MAX_BLOCKS];
   logic [DRT_LEN_W-1:0]   entry_length_ff [MAX_BLOCKS];
   logic [CntW-1:0]        count_ff, count_in;

   drt_back_state_type     state_ff, state_in;
   drt_item_type           item_ff;
   logic [MAX_BLOCKS-1:0]  hit_vec, join_vec;
   logic [MAX_BLOCKS-1:0]  hit_vec_ff, join_vec_ff;
   logic [DRT_END_W-1:0]   lane_end [MAX_BLOCKS];

   logic                   any_hit, have_join, table_full, overflow;
   logic [IdxW-1:0]        join_idx;
   logic [DRT_END_W-1:0]   grown;
   logic [DRT_LEN_W-1:0]   grown_len;

   // per-lane overlap and abutment compare against the queue head
   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_lane
      logic                 lane_valid;
      logic [DRT_END_W-1:0] b_lo, r_lo, r_hi;
      assign lane_valid  = (CntW'(g) < count_ff);
      assign b_lo        = DRT_END_W'(entry_start_ff[g]);
      assign lane_end[g] = b_lo + DRT_END_W'(entry_length_ff[g]);
      assign r_lo        = DRT_END_W'(head.range_start);
      assign r_hi        = head.range_end;
      assign hit_vec[g]  = lane_valid &&
                           ((b_lo <= r_lo && r_lo < lane_end[g]) ||
                            (b_lo < r_hi && r_hi <= lane_end[g]) ||
                            (r_lo <= b_lo && b_lo < r_hi) ||
                            (r_lo < lane_end[g] && lane_end[g] <= r_hi));
      assign join_vec[g] = lane_valid && (lane_end[g] == r_lo);
   end

   // reduce registered compare vectors, highest joining lane wins
   always_comb begin
      join_idx = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         if (join_vec_ff[i]) begin
            join_idx = IdxW'(i);
         end
      end
   end

   assign any_hit    = |hit_vec_ff;
   assign have_join  = |join_vec_ff;
   assign table_full = (count_ff == CntW'(MAX_BLOCKS));
   assign overflow   = !any_hit && !have_join && table_full;

   // grown length saturates at all ones
   assign grown     = DRT_END_W'(entry_length_ff[join_idx]) + DRT_END_W'(item_ff.range_length);
   assign grown_len = grown[DRT_END_W-1] ? '1 : grown[DRT_LEN_W-1:0];

   assign rsp_word.overlap_found  = any_hit;
   assign rsp_word.table_overflow = overflow;

   // sequencer: compare, then update
   always_comb begin
      state_in = state_ff;
      head_pop = 1'b0;
      rsp_push = 1'b0;
      unique case (state_ff)
         BK_COMPARE: begin
            if (!head_empty) begin
               head_pop = 1'b1;
               state_in = BK_UPDATE;
            end
         end
         BK_UPDATE: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = BK_COMPARE;
            end
         end
      endcase
   end

   // next block count
   always_comb begin
      count_in = count_ff;
      if (rsp_push) begin
         priority if (any_hit || overflow) begin
            count_in = CntW'(1);
         end else if (!have_join) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_COMPARE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // compare results and the word under work
   always_ff @(posedge clock) begin
      if (head_pop) begin
         item_ff     <= head;
         hit_vec_ff  <= hit_vec;
         join_vec_ff <= join_vec;
      end
   end

   // table write: restart, grow or append
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         priority if (any_hit || overflow) begin
            entry_start_ff[0]  <= item_ff.range_start;
            entry_length_ff[0] <= DRT_LEN_W'(item_ff.range_length);
         end else if (have_join) begin
            entry_length_ff[join_idx] <= grown_len;
         end else begin
            entry_start_ff[count_ff[IdxW-1:0]]  <= item_ff.range_start;
            entry_length_ff[count_ff[IdxW-1:0]] <= DRT_LEN_W'(item_ff.range_length);
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MAX_BLOCKS))
      else $error("block count above table depth");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !(rsp_word.overlap_found && rsp_word.table_overflow))
      else $error("overlap and overflow reported together");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_push && (any_hit || overflow) |=> count_ff == CntW'(1))
      else $error("table restart did not leave one block");

   a_append: assert property (@(posedge clock) disable iff (reset)
      rsp_push && !any_hit && !have_join && !table_full
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the block count");

   a_pop_update: assert property (@(posedge clock) disable iff (reset)
      head_pop |=> state_ff == BK_UPDATE && !head_pop)
      else $error("compare not followed by update");
`endif

endmodule

>>> rtl/core/dirty_range_tracker_core.sv
// ----------------------------------------------------------------------------
// dirty_range_tracker_core
// Tracks which byte ranges of a buffer were written since the last discard.
// ----------------------------------------------------------------------------
// Usage:
//   Request side is a queue: drive req_range_start/req_range_length with
//   req_push; a word is taken on a clock edge with req_push high and
//   req_full low. Result side is a queue too: while rsp_empty is low the
//   oldest result flags are on rsp_overlap_found/rsp_table_overflow, and
//   rsp_pop with rsp_empty low takes them. Exactly one result per request.
//   A request taken into an idle block is compared with the table while it
//   heads the request queue, then the update step pushes its result word.
//   The compare/update sequencer that owns the block table takes a new
//   request only after the last one has pushed its result; all MAX_BLOCKS
//   entries are compared in parallel in the compare step.
//   Two-word queues on both sides let requests arrive while a result waits.
//   If rsp_pop stays low, the result queue fills, the table stops after its
//   compare cycle, the request queue fills and req_full rises; nothing is
//   dropped. Synchronous reset empties both queues and the table.
// ----------------------------------------------------------------------------
module dirty_range_tracker_core
   import drt_pkg::*;
#(
   parameter int MAX_BLOCKS = DRT_MAX_BLOCKS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [DRT_START_W-1:0]  req_range_start,
   input  logic [DRT_REQLEN_W-1:0] req_range_length,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_overlap_found,
   output logic                    rsp_table_overflow
);

   drt_item_type         head;
   logic                 head_empty, head_pop;
   logic                 rsp_full, rsp_push;
   drt_rsp_type          rsp_word, rsp_head;
   logic [DRT_RSP_W-1:0] rsp_bits;

   // request intake
   drt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_range_start  (req_range_start),
      .req_range_length (req_range_length),
      .head             (head),
      .head_empty       (head_empty),
      .head_pop         (head_pop)
   );

   // block table
   drt_back #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .rsp_full   (rsp_full),
      .rsp_push   (rsp_push),
      .rsp_word   (rsp_word)
   );

   // result queue
   drt_queue #(
      .WIDTH (DRT_RSP_W)
   ) u_rsp_queue (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .full  (rsp_full),
      .wdata (rsp_word),
      .empty (rsp_empty),
      .pop   (rsp_pop),
      .rdata (rsp_bits)
   );

   assign rsp_head           = drt_rsp_type'(rsp_bits);
   assign rsp_overlap_found  = rsp_head.overlap_found;
   assign rsp_table_overflow = rsp_head.table_overflow;

endmodule
